@@ sv/urf_pkg.sv @@
// ----------------------------------------------------------------------------
// urf_pkg
// shared types and constants for the uart receive fifo with rts flow control
// ----------------------------------------------------------------------------
package urf_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LVL_W  = 9;
  localparam int CMP_W  = (CNT_W > LVL_W) ? CNT_W : LVL_W;
  localparam int CIDX_W = 2;

  localparam logic [LVL_W-1:0] PAUSE_RESET  = LVL_W'(64);
  localparam logic [LVL_W-1:0] RESUME_RESET = LVL_W'(128);

  typedef enum logic [1:0] {
    CMD_RX     = 2'd0,
    CMD_READ   = 2'd1,
    CMD_TXDONE = 2'd2,
    CMD_SEND   = 2'd3
  } cmd_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PAUSE  = CIDX_W'(0),
    CFG_RESUME = CIDX_W'(1)
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

@@ sv/urf_ctrl.sv @@
// ----------------------------------------------------------------------------
// urf_ctrl
// sequencer: takes a request, runs the execute state, strobes the result
// ----------------------------------------------------------------------------
module urf_ctrl
  import urf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.exec;
    end
  end

  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.exec   = 1'b0;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        ctl.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/urf_dp.sv @@
// ----------------------------------------------------------------------------
// urf_dp
// ring memory, pointers, free count, rts hysteresis and transmit ready flag
// ----------------------------------------------------------------------------
module urf_dp
  import urf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [LVL_W-1:0]  cfg_data,
  output logic [7:0]        read_data,
  output logic              read_valid,
  output logic [7:0]        tx_byte,
  output logic              tx_start,
  output logic              rts_out,
  output logic              overflow,
  output logic              char_available,
  output logic              tx_ready
);

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_PTR  = ADDR_W'(DEPTH - 1);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        mem_q;
  logic [ADDR_W-1:0] wr_ptr, rd_ptr;
  logic [ADDR_W-1:0] wr_ptr_next, rd_ptr_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic              rts_level, rts_level_next;
  logic              xmit_rdy, xmit_rdy_next;
  logic [LVL_W-1:0]  pause_level, resume_level;
  cmd_t              cmd_q;
  logic [7:0]        byte_q;
  logic              mem_we;
  logic [7:0]        rd_data_next, tx_byte_next;
  logic              rd_valid_next, tx_start_next, ovf_next;
  logic [CMP_W-1:0]  pause_ext, resume_ext;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= byte_q;
    end
    mem_q <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd_t'(cmd);
      byte_q <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pause_level  <= PAUSE_RESET;
      resume_level <= RESUME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAUSE:  pause_level  <= cfg_data;
        CFG_RESUME: resume_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pause_ext  = CMP_W'(pause_level);
  assign resume_ext = CMP_W'(resume_level);

  always_comb begin
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    free_count_next = free_count;
    rts_level_next  = rts_level;
    xmit_rdy_next   = xmit_rdy;
    mem_we          = 1'b0;
    rd_data_next    = 8'd0;
    rd_valid_next   = 1'b0;
    tx_byte_next    = 8'd0;
    tx_start_next   = 1'b0;
    ovf_next        = 1'b0;
    case (cmd_q)
      CMD_RX: begin
        if (free_count == '0) begin
          ovf_next = 1'b1;
        end else begin
          mem_we          = ctl.exec;
          wr_ptr_next     = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
          free_count_next = free_count - 1'b1;
        end
      end
      CMD_READ: begin
        if (free_count != DEPTH_CNT) begin
          rd_data_next    = mem_q;
          rd_valid_next   = 1'b1;
          rd_ptr_next     = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
          free_count_next = free_count + 1'b1;
        end
      end
      CMD_TXDONE: begin
        xmit_rdy_next = 1'b1;
      end
      CMD_SEND: begin
        if (xmit_rdy) begin
          tx_byte_next  = byte_q;
          tx_start_next = 1'b1;
          xmit_rdy_next = 1'b0;
        end
      end
      default: ;
    endcase
    if (cmd_q == CMD_RX && !ovf_next && !rts_level &&
        CMP_W'(free_count_next) < pause_ext) begin
      rts_level_next = 1'b1;
    end
    if (rd_valid_next && rts_level && CMP_W'(free_count_next) > resume_ext) begin
      rts_level_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      free_count <= DEPTH_CNT;
      rts_level  <= 1'b0;
      xmit_rdy   <= 1'b1;
    end else if (ctl.exec) begin
      wr_ptr     <= wr_ptr_next;
      rd_ptr     <= rd_ptr_next;
      free_count <= free_count_next;
      rts_level  <= rts_level_next;
      xmit_rdy   <= xmit_rdy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      read_data      <= rd_data_next;
      read_valid     <= rd_valid_next;
      tx_byte        <= tx_byte_next;
      tx_start       <= tx_start_next;
      rts_out        <= rts_level_next;
      overflow       <= ovf_next;
      char_available <= (free_count_next != DEPTH_CNT);
      tx_ready       <= xmit_rdy_next;
    end
  end

endmodule

@@ sv/uart_rx_fifo_rts_flow_control.sv @@
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_flow_control
// uart receive ring with rts hysteresis and a transmit ready flag
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  request  | start, busy            | cmd, data_byte
//  result   | done (one-cycle pulse) | read_data, read_valid, tx_byte,
//           |                        | tx_start, rts_out, overflow,
//           |                        | char_available, tx_ready
//  config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
//  each request first reads the ring memory at the read pointer (registered
//  read port), then updates state and registers the result
//  done pulses the cycle after; a new request may be taken in that same cycle
//  synchronous reset; no clearing pass, ring contents are undefined until written
//  the result cannot be stalled; cfg_ready is always high
// ----------------------------------------------------------------------------
module uart_rx_fifo_rts_flow_control
  import urf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd,
  input  logic [7:0]        data_byte,
  output logic              done,
  output logic [7:0]        read_data,
  output logic              read_valid,
  output logic [7:0]        tx_byte,
  output logic              tx_start,
  output logic              rts_out,
  output logic              overflow,
  output logic              char_available,
  output logic              tx_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [LVL_W-1:0]  cfg_data
);

  ctl_t ctl;

  assign cfg_ready = 1'b1;

  urf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  urf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .read_data      (read_data),
    .read_valid     (read_valid),
    .tx_byte        (tx_byte),
    .tx_start       (tx_start),
    .rts_out        (rts_out),
    .overflow       (overflow),
    .char_available (char_available),
    .tx_ready       (tx_ready)
  );

endmodule
